FILE: src/asp_pkg.sv
package asp_pkg;

  // Default operand width in bits.
  localparam int unsigned WidthDef = 32;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_ADDD   = 6'b001000,
    ST_ADDQ   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

endpackage

FILE: src/asp_in_if.sv
interface asp_in_if
  import asp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDef
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] n_value;

  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

FILE: src/asp_out_if.sv
interface asp_out_if
  import asp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDef
);
  logic             valid;
  logic             ready;
  logic [WIDTH+2:0] divisor_sum;
  logic             is_perfect;

  modport source (output valid, output divisor_sum, output is_perfect, input ready);
  modport sink   (input valid, input divisor_sum, input is_perfect, output ready);
endinterface

FILE: src/aliquot_sum_perfect_test.sv
// Sequence: an item with n < 2 goes from accept straight to ST_FINISH; otherwise each
//   trial divisor passes through ST_CHECK, ST_DIV, ST_ADDD and ST_ADDQ, with the restoring
//   divider in ST_DIV retiring one quotient bit per cycle for each trial divisor.
// Throughput: one item at a time; in_i.ready is high only while the sequencer idles.
//   A finished result waits in the output register while the next item is taken.
// Reset: rst_ni clears the sequencer and the output valid; no item is held.
module aliquot_sum_perfect_test
  import asp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  asp_in_if.sink    in_i,
  asp_out_if.source out_o
);

  // Trial divisor width: WIDTH/2 + 2 bits, so d stays below 2^(WIDTH/2 + 2).
  localparam int unsigned DW   = WIDTH / 2 + 2;
  // d*d may step just past n, so it gets two extra bits.
  localparam int unsigned SQW  = WIDTH + 2;
  localparam int unsigned SUMW = WIDTH + 3;
  localparam int unsigned CW   = $clog2(WIDTH + 1);

  state_e            state_q, state_d;
  logic [WIDTH-1:0]  n_q, n_d;          // operand under test
  logic [DW-1:0]     d_q, d_d;          // trial divisor
  logic [SQW-1:0]    sq_q, sq_d;        // d*d, kept by increment
  logic [WIDTH-1:0]  dvd_q, dvd_d;      // dividend bits out, quotient bits in
  logic [DW-1:0]     rem_q, rem_d;      // partial remainder, always below d
  logic [CW-1:0]     cnt_q, cnt_d;      // divide step count
  logic [SUMW-1:0]   sum_q, sum_d;      // running divisor sum
  logic              out_valid_q, out_valid_d;
  logic [SUMW-1:0]   out_sum_q, out_sum_d;
  logic              out_perf_q, out_perf_d;

  logic [DW:0]       trial;
  logic              trial_ge;
  logic              out_free;

  // One restoring divide step: bring down the next dividend bit and try d.
  assign trial    = {rem_q, dvd_q[WIDTH-1]};
  assign trial_ge = (trial >= {1'b0, d_q});
  // Output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_perf_d  = out_perf_q;

    // Drop the result once taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          n_d  = in_i.n_value;
          d_d  = DW'(2);
          sq_d = SQW'(4);
          if (in_i.n_value < WIDTH'(2)) begin
            // Zero and one have no proper divisors.
            sum_d   = '0;
            state_d = ST_FINISH;
          end else begin
            // Divisor one counts for every n of two or more.
            sum_d   = SUMW'(1);
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > {2'b00, n_q}) begin
          state_d = ST_FINISH;
        end else begin
          dvd_d   = n_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_d = {dvd_q[WIDTH-2:0], trial_ge};
        if (trial_ge) begin
          rem_d = DW'(trial - {1'b0, d_q});
        end else begin
          rem_d = trial[DW-1:0];
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WIDTH - 1)) begin
          state_d = ST_ADDD;
        end
      end
      ST_ADDD: begin
        if (rem_q == '0) begin
          sum_d = sum_q + {{(SUMW-DW){1'b0}}, d_q};
        end
        state_d = ST_ADDQ;
      end
      ST_ADDQ: begin
        // Add the paired quotient, but only once for a square root.
        if (rem_q == '0 && dvd_q != {{(WIDTH-DW){1'b0}}, d_q}) begin
          sum_d = sum_q + {3'b000, dvd_q};
        end
        d_d     = d_q + DW'(1);
        sq_d    = sq_q + {{(SQW-DW-1){1'b0}}, d_q, 1'b1};
        state_d = ST_CHECK;
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          out_perf_d  = (n_q != '0) && ({3'b000, n_q} == sum_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    sum_q     <= sum_d;
    out_sum_q <= out_sum_d;
    out_perf_q <= out_perf_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.divisor_sum = out_sum_q;
  assign out_o.is_perfect  = out_perf_q;

  // Partial remainder stays below the trial divisor through the divide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < d_q))
    else $error("remainder not below trial divisor");

  // A taken result clears unless a new one is loaded in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ready && state_q != ST_FINISH) |=> !out_valid_q)
    else $error("result delivered twice");

  // A perfect flag implies a nonzero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_perf_q) |-> (out_sum_q != '0))
    else $error("perfect flag with zero sum");

endmodule
